FILE: hw/rtl/serial_command_frame_receiver_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the serial command frame receiver
// Wraps concurrent assertions so that synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_FRAME_RECEIVER_CORE_MACROS_SVH
`define SERIAL_COMMAND_FRAME_RECEIVER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// antecedent in this cycle implies consequent in the same cycle
`define SCFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scfr assertion failed");
// antecedent in this cycle implies consequent in the next cycle
`define SCFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scfr assertion failed");
// condition holds on every cycle out of reset
`define SCFR_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("scfr assertion failed");
`else
`define SCFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SCFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define SCFR_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`endif

`endif

FILE: hw/rtl/scfr_pkg.sv
// ----------------------------------------------------------------------------
// Serial command frame receiver package
// Frame constants, phase and result codes, result record and CRC-16 step.
// ----------------------------------------------------------------------------
package scfr_pkg;

  localparam logic [7:0]  HdrByte   = 8'hEC;
  localparam logic [7:0]  TailByte  = 8'hBE;
  localparam logic [7:0]  ZeroByte  = 8'h00;
  localparam logic [15:0] CrcPreset = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'hA001;

  // one reflected crc-16 byte step, eight shifts
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // crc after the header byte alone
  localparam logic [15:0] CrcHdr = crc_byte(CrcPreset, HdrByte);

  typedef enum logic [13:0] {
    PhWait = 14'h0001,
    PhLen  = 14'h0002,
    PhNlen = 14'h0004,
    PhTgt  = 14'h0008,
    PhSrc  = 14'h0010,
    PhOp   = 14'h0020,
    PhA3   = 14'h0040,
    PhA2   = 14'h0080,
    PhA1   = 14'h0100,
    PhA0   = 14'h0200,
    PhData = 14'h0400,
    PhCrch = 14'h0800,
    PhCrcl = 14'h1000,
    PhTail = 14'h2000
  } phase_e;

  typedef enum logic [1:0] {
    KindPayload  = 2'd0,
    KindAccepted = 2'd1,
    KindRejected = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ReasonNone     = 2'd0,
    ReasonBadTail  = 2'd1,
    ReasonCrc      = 2'd2,
    ReasonNotHere  = 2'd3
  } reason_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [7:0]  target_id;
    logic [7:0]  source_id;
    logic [7:0]  operation;
    logic [15:0] addr_high;
    logic [15:0] addr_low;
    logic [7:0]  data_length;
    reason_e     reject_reason;
  } result_t;

endpackage

FILE: hw/rtl/scfr_parser.sv
// ----------------------------------------------------------------------------
// Frame parser
// Walks the frame phases one byte per enable, keeps the running CRC and
// header fields, and produces at most one result per byte.
// ----------------------------------------------------------------------------
module scfr_parser
  import scfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] device_id_i,
  output logic       res_vld_o,
  output result_t    res_o,
  output phase_e     phase_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  tgt_q, tgt_d;
  logic [7:0]  src_q, src_d;
  logic [7:0]  op_q, op_d;
  logic [15:0] addr_hi_q, addr_hi_d;
  logic [15:0] addr_lo_q, addr_lo_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] rx_crc_q, rx_crc_d;

  logic [15:0] crc_base;
  logic [7:0]  crc_in;
  logic [15:0] crc_next;
  logic [8:0]  cnt_inc;
  logic        res_vld;
  reason_e     reason;

  // upper address bytes go into the crc as zero
  assign crc_in   = (phase_q == PhA3 || phase_q == PhA2) ? ZeroByte : byte_i;
  // stored length was really a header: restart the crc from the header
  assign crc_base = (phase_q == PhNlen && len_q != ~byte_i && len_q == HdrByte) ?
                    CrcHdr : crc_q;
  assign crc_next = crc_byte(crc_base, crc_in);
  assign cnt_inc  = {1'b0, cnt_q} + 9'd1;

  always_comb begin
    phase_d   = phase_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    tgt_d     = tgt_q;
    src_d     = src_q;
    op_d      = op_q;
    addr_hi_d = addr_hi_q;
    addr_lo_d = addr_lo_q;
    crc_d     = crc_q;
    rx_crc_d  = rx_crc_q;
    res_vld   = 1'b0;
    reason    = ReasonNone;

    res_o.kind          = KindPayload;
    res_o.data_byte     = ZeroByte;
    res_o.byte_index    = ZeroByte;
    res_o.target_id     = tgt_q;
    res_o.source_id     = src_q;
    res_o.operation     = op_q;
    res_o.addr_high     = addr_hi_q;
    res_o.addr_low      = addr_lo_q;
    res_o.data_length   = len_q;
    res_o.reject_reason = ReasonNone;

    unique case (phase_q)
      PhLen: begin
        len_d   = byte_i;
        crc_d   = crc_next;
        phase_d = PhNlen;
      end
      PhNlen: begin
        if (len_q == ~byte_i) begin
          crc_d   = crc_next;
          phase_d = PhTgt;
        end else if (len_q == HdrByte) begin
          // stored length was really a header: resync on this byte
          len_d    = byte_i;
          crc_d    = crc_next;
          phase_d  = PhNlen;
        end else if (byte_i == HdrByte) begin
          crc_d   = CrcHdr;
          phase_d = PhLen;
        end else begin
          phase_d = PhWait;
        end
      end
      PhTgt: begin
        tgt_d   = byte_i;
        crc_d   = crc_next;
        phase_d = PhSrc;
      end
      PhSrc: begin
        src_d   = byte_i;
        crc_d   = crc_next;
        phase_d = PhOp;
      end
      PhOp: begin
        op_d    = byte_i;
        crc_d   = crc_next;
        phase_d = PhA3;
      end
      PhA3: begin
        addr_hi_d = {8'h00, byte_i};
        crc_d     = crc_next;
        phase_d   = PhA2;
      end
      PhA2: begin
        addr_hi_d = {addr_hi_q[7:0], byte_i};
        crc_d     = crc_next;
        phase_d   = PhA1;
      end
      PhA1: begin
        addr_lo_d = {8'h00, byte_i};
        crc_d     = crc_next;
        phase_d   = PhA0;
      end
      PhA0: begin
        addr_lo_d = {addr_lo_q[7:0], byte_i};
        crc_d     = crc_next;
        if (len_q != ZeroByte) begin
          cnt_d   = ZeroByte;
          phase_d = PhData;
        end else begin
          phase_d = PhCrch;
        end
      end
      PhData: begin
        cnt_d = cnt_inc[7:0];
        // also ends on counter wrap
        if (cnt_inc >= {1'b0, len_q}) begin
          phase_d = PhCrch;
        end
        crc_d            = crc_next;
        res_vld          = 1'b1;
        res_o.data_byte  = byte_i;
        res_o.byte_index = cnt_q;
      end
      PhCrch: begin
        rx_crc_d = {8'h00, byte_i};
        phase_d  = PhCrcl;
      end
      PhCrcl: begin
        rx_crc_d = {rx_crc_q[7:0], byte_i};
        phase_d  = PhTail;
      end
      PhTail: begin
        phase_d = PhWait;
        if (byte_i != TailByte) begin
          reason = ReasonBadTail;
        end else if (rx_crc_q != crc_q) begin
          reason = ReasonCrc;
        end else if (tgt_q != device_id_i && tgt_q != ZeroByte) begin
          reason = ReasonNotHere;
        end else begin
          reason = ReasonNone;
        end
        res_vld             = 1'b1;
        res_o.kind          = (reason == ReasonNone) ? KindAccepted : KindRejected;
        res_o.reject_reason = reason;
      end
      default: begin
        phase_d = PhWait;
        if (byte_i == HdrByte) begin
          crc_d   = CrcHdr;
          phase_d = PhLen;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhWait;
      len_q     <= '0;
      cnt_q     <= '0;
      tgt_q     <= '0;
      src_q     <= '0;
      op_q      <= '0;
      addr_hi_q <= '0;
      addr_lo_q <= '0;
      crc_q     <= '0;
      rx_crc_q  <= '0;
    end else if (en_i) begin
      phase_q   <= phase_d;
      len_q     <= len_d;
      cnt_q     <= cnt_d;
      tgt_q     <= tgt_d;
      src_q     <= src_d;
      op_q      <= op_d;
      addr_hi_q <= addr_hi_d;
      addr_lo_q <= addr_lo_d;
      crc_q     <= crc_d;
      rx_crc_q  <= rx_crc_d;
    end
  end

  assign res_vld_o = en_i & res_vld;
  assign phase_o   = phase_q;

endmodule

FILE: hw/rtl/serial_command_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// Serial command frame receiver core
// Parses 0xEC ... 0xBE command frames from a byte stream, passes payload
// bytes on and reports each frame as accepted or rejected.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle on the slave stream and keeps that rate
// indefinitely while the master side takes results. Each byte goes through
// an input register and one pass of parse logic (phase update plus a single
// byte-wide CRC-16 step) into the result register, whose contents drive the
// master stream tvalid and tdata; header bytes give no result, each
// payload byte gives one, the tail byte gives the accept or reject word. A
// stalled master side holds the result register and backs up into the input
// register before tready drops. device_id is written over the cfg channel,
// which is always ready, and should only change between frames.
module serial_command_frame_receiver_core
  import scfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,     // device_id
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // data_byte, byte_index, target_id, source_id, operation, addr_high,
  // addr_low, data_length, reject_reason, zero pad
  output logic [87:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser    // kind
);

  `include "serial_command_frame_receiver_core_macros.svh"

  logic [7:0] dev_id_q;
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  result_t    out_q;

  logic       adv;
  logic       proc;
  logic       res_vld;
  result_t    res;
  phase_e     phase;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_id_q <= 8'd1;
    end else if (cfg_valid_i) begin
      dev_id_q <= cfg_data_i;
    end
  end

  // result register free or being emptied this cycle
  assign adv           = !out_vld_q || m_axis_tready;
  assign proc          = in_vld_q && adv;
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  scfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (proc),
    .byte_i      (in_byte_q),
    .device_id_i (dev_id_q),
    .res_vld_o   (res_vld),
    .res_o       (res),
    .phase_o     (phase)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {6'b0, out_q.reject_reason, out_q.data_length, out_q.addr_low,
                          out_q.addr_high, out_q.operation, out_q.source_id,
                          out_q.target_id, out_q.byte_index, out_q.data_byte};

  `SCFR_ASSERT_ALWAYS(a_phase_onehot, clk_i, rst_ni, $onehot(phase))
  `SCFR_ASSERT_NOW(a_reason_matches_kind, clk_i, rst_ni, out_vld_q,
    ((out_q.kind == KindRejected) == (out_q.reject_reason != ReasonNone)))
  `SCFR_ASSERT_NEXT(a_input_held, clk_i, rst_ni, in_vld_q && !adv,
    in_vld_q && $stable(in_byte_q))
  `SCFR_ASSERT_NOW(a_result_only_from_payload_or_tail, clk_i, rst_ni, res_vld,
    (phase == PhData) || (phase == PhTail))

endmodule

FILE: tb/serial_command_frame_receiver_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial command frame receiver core testbench
// Sends command frames, broken frames and line noise byte by byte, predicts
// every payload word and every accept or reject word from a frame parser of
// its own, and checks each result word against it. Both stream sides idle and
// stall at random across several device_id settings.
// ----------------------------------------------------------------------------
module serial_command_frame_receiver_core_tb;
  import scfr_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int PhaseBytes  = 170;
  localparam int DrainCycles = 8;
  localparam int LongHold    = 300;

  // one directed frame: optional lead-in bytes, then a complete frame
  typedef struct packed {
    logic [1:0]  npre;
    logic [23:0] pre;       // first lead-in byte in the low bits
    logic [7:0]  len;
    logic [7:0]  tgt;
    logic [7:0]  src;
    logic [7:0]  op;
    logic [31:0] addr;
    logic [7:0]  pay_base;
    logic        crc_bad;
    logic [7:0]  tail;
    kind_e       kind;
    reason_e     reason;
  } frame_row_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data      = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // parser state mirrored by the testbench
  phase_e      fr_phase;
  logic [7:0]  own_id;
  logic [7:0]  fr_len;
  logic [7:0]  pay_cnt;
  logic [7:0]  fr_tgt;
  logic [7:0]  fr_src;
  logic [7:0]  fr_op;
  logic [15:0] fr_addr_hi;
  logic [15:0] fr_addr_lo;
  logic [15:0] crc_run;
  logic [15:0] crc_rx;

  result_t     pending_words [$];
  int          err_count   = 0;
  int          cycle_count = 0;
  int          bytes_sent  = 0;
  int          snd_pct     = 0;
  int          rcv_pct     = 0;
  int          stall_req   = 0;
  int          stalls_seen = 0;
  int          hold_left   = 0;

  frame_row_t dir_rows [9] = '{
    '{2'd0, 24'h000000, 8'h00, 8'h01, 8'h00, 8'h00, 32'h0000_0000, 8'h00, 1'b0,
      TailByte, KindAccepted, ReasonNone},
    // line noise first, all-ones source, operation and address, broadcast target
    '{2'd3, 24'hBEFF00, 8'h01, 8'h00, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 1'b0,
      TailByte, KindAccepted, ReasonNone},
    // stored length was a header byte
    '{2'd2, 24'h00ECEC, 8'h02, 8'h01, 8'h12, 8'h34, 32'h1234_5678, 8'h80, 1'b0,
      TailByte, KindAccepted, ReasonNone},
    // bad inverted length that is a header byte restarts the frame
    '{2'd2, 24'h0010EC, 8'h03, 8'h00, 8'h5A, 8'hA5, 32'h8000_0001, 8'h10, 1'b0,
      TailByte, KindAccepted, ReasonNone},
    // bad inverted length drops back to waiting, then a bad tail
    '{2'd3, 24'h2210EC, 8'h01, 8'h01, 8'h01, 8'h02, 32'h0102_0304, 8'h33, 1'b0,
      8'h00, KindRejected, ReasonBadTail},
    // bad tail wins over a crc mismatch
    '{2'd0, 24'h000000, 8'h01, 8'h01, 8'h02, 8'h03, 32'h0000_FFFF, 8'h44, 1'b1,
      8'hBF, KindRejected, ReasonBadTail},
    // crc mismatch wins over a foreign target
    '{2'd0, 24'h000000, 8'h02, 8'h07, 8'h03, 8'h04, 32'hFFFF_0000, 8'h55, 1'b1,
      TailByte, KindRejected, ReasonCrc},
    '{2'd0, 24'h000000, 8'h00, 8'hFF, 8'h04, 8'h05, 32'hAAAA_5555, 8'h00, 1'b0,
      TailByte, KindRejected, ReasonNotHere},
    // longest payload
    '{2'd0, 24'h000000, 8'hFF, 8'h01, 8'h05, 8'h06, 32'h5555_AAAA, 8'h00, 1'b0,
      TailByte, KindAccepted, ReasonNone}
  };

  serial_command_frame_receiver_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("serial_command_frame_receiver_core_tb: errors");
    $finish;
  end

  // modbus style crc-16, lsb first
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    return r;
  endfunction

  // advance the mirrored parser by one byte; returns 1 when a word is due
  function automatic bit parse_byte(input logic [7:0] b, output result_t w);
    bit      emit;
    reason_e rs;
    emit = 1'b0;
    w    = '0;
    case (fr_phase)
      PhLen: begin
        fr_len   = b;
        crc_run  = crc16_step(crc_run, b);
        fr_phase = PhNlen;
      end
      PhNlen: begin
        if (fr_len == 8'(~b)) begin
          crc_run  = crc16_step(crc_run, b);
          fr_phase = PhTgt;
        end else if (fr_len == HdrByte) begin
          fr_len   = b;
          crc_run  = crc16_step(crc16_step(CrcPreset, HdrByte), b);
          fr_phase = PhNlen;
        end else if (b == HdrByte) begin
          crc_run  = crc16_step(CrcPreset, HdrByte);
          fr_phase = PhLen;
        end else begin
          fr_phase = PhWait;
        end
      end
      PhTgt: begin
        fr_tgt   = b;
        crc_run  = crc16_step(crc_run, b);
        fr_phase = PhSrc;
      end
      PhSrc: begin
        fr_src   = b;
        crc_run  = crc16_step(crc_run, b);
        fr_phase = PhOp;
      end
      PhOp: begin
        fr_op    = b;
        crc_run  = crc16_step(crc_run, b);
        fr_phase = PhA3;
      end
      PhA3: begin
        fr_addr_hi = {8'h00, b};
        crc_run    = crc16_step(crc_run, ZeroByte);
        fr_phase   = PhA2;
      end
      PhA2: begin
        fr_addr_hi = {fr_addr_hi[7:0], b};
        crc_run    = crc16_step(crc_run, ZeroByte);
        fr_phase   = PhA1;
      end
      PhA1: begin
        fr_addr_lo = {8'h00, b};
        crc_run    = crc16_step(crc_run, b);
        fr_phase   = PhA0;
      end
      PhA0: begin
        fr_addr_lo = {fr_addr_lo[7:0], b};
        crc_run    = crc16_step(crc_run, b);
        if (fr_len != 8'h00) begin
          pay_cnt  = 8'h00;
          fr_phase = PhData;
        end else begin
          fr_phase = PhCrch;
        end
      end
      PhData: begin
        w.kind       = KindPayload;
        w.data_byte  = b;
        w.byte_index = pay_cnt;
        pay_cnt      = pay_cnt + 8'd1;
        if (pay_cnt >= fr_len || pay_cnt == 8'h00) fr_phase = PhCrch;
        crc_run = crc16_step(crc_run, b);
        emit    = 1'b1;
      end
      PhCrch: begin
        crc_rx   = {8'h00, b};
        fr_phase = PhCrcl;
      end
      PhCrcl: begin
        crc_rx   = {crc_rx[7:0], b};
        fr_phase = PhTail;
      end
      PhTail: begin
        fr_phase = PhWait;
        if (b != TailByte) rs = ReasonBadTail;
        else if (crc_rx != crc_run) rs = ReasonCrc;
        else if (fr_tgt != own_id && fr_tgt != 8'h00) rs = ReasonNotHere;
        else rs = ReasonNone;
        if (rs == ReasonNone) w.kind = KindAccepted;
        else w.kind = KindRejected;
        w.reject_reason = rs;
        emit = 1'b1;
      end
      default: begin
        fr_phase = PhWait;
        if (b == HdrByte) begin
          crc_run  = crc16_step(CrcPreset, HdrByte);
          fr_phase = PhLen;
        end
      end
    endcase
    if (emit) begin
      w.target_id   = fr_tgt;
      w.source_id   = fr_src;
      w.operation   = fr_op;
      w.addr_high   = fr_addr_hi;
      w.addr_low    = fr_addr_lo;
      w.data_length = fr_len;
    end
    return emit;
  endfunction

  // offer one byte, optionally after an idle gap; pin overrides kind and reason
  task automatic send_byte(input logic [7:0] b, input bit pin = 1'b0,
                           input kind_e pk = KindPayload, input reason_e pr = ReasonNone);
    result_t w;
    if (snd_pct != 0 && $urandom_range(99) < snd_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < snd_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    if (parse_byte(b, w)) begin
      if (pin) begin
        w.kind          = pk;
        w.reject_reason = pr;
      end
      pending_words.push_back(w);
    end
  endtask

  task automatic send_frame(input logic [7:0] len, input logic [7:0] tgt,
                            input logic [7:0] src, input logic [7:0] op,
                            input logic [31:0] addr, input bit rand_pay,
                            input logic [7:0] pay_base, input bit crc_bad,
                            input logic [7:0] tail, input bit pin,
                            input kind_e pk, input reason_e pr);
    logic [15:0] c;
    logic [7:0]  pay;
    c = crc16_step(CrcPreset, HdrByte);
    send_byte(HdrByte);
    send_byte(len);
    c = crc16_step(c, len);
    send_byte(~len);
    c = crc16_step(c, ~len);
    send_byte(tgt);
    c = crc16_step(c, tgt);
    send_byte(src);
    c = crc16_step(c, src);
    send_byte(op);
    c = crc16_step(c, op);
    // upper address bytes count as zero in the crc
    send_byte(addr[31:24]);
    c = crc16_step(c, ZeroByte);
    send_byte(addr[23:16]);
    c = crc16_step(c, ZeroByte);
    send_byte(addr[15:8]);
    c = crc16_step(c, addr[15:8]);
    send_byte(addr[7:0]);
    c = crc16_step(c, addr[7:0]);
    for (int k = 0; k < len; k++) begin
      pay = rand_pay ? 8'($urandom_range(255)) : 8'(pay_base + k);
      send_byte(pay);
      c = crc16_step(c, pay);
    end
    if (crc_bad) c = c ^ (16'h0001 << $urandom_range(15));
    send_byte(c[15:8]);
    send_byte(c[7:0]);
    send_byte(tail, pin, pk, pr);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_device_id(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    own_id = v;
  endtask

  task automatic cmp_field(input string fname, input logic [15:0] want,
                           input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
      err_count++;
    end
  endtask

  task automatic check_word();
    result_t want;
    if (pending_words.size() == 0) begin
      $display("%0t: unexpected word, expected none, got tuser %h tdata %h",
               $time, m_axis_tuser, m_axis_tdata);
      err_count++;
    end else begin
      want = pending_words.pop_front();
      cmp_field("kind", 16'(want.kind), 16'(m_axis_tuser));
      cmp_field("data_byte", 16'(want.data_byte), 16'(m_axis_tdata[7:0]));
      cmp_field("byte_index", 16'(want.byte_index), 16'(m_axis_tdata[15:8]));
      cmp_field("target_id", 16'(want.target_id), 16'(m_axis_tdata[23:16]));
      cmp_field("source_id", 16'(want.source_id), 16'(m_axis_tdata[31:24]));
      cmp_field("operation", 16'(want.operation), 16'(m_axis_tdata[39:32]));
      cmp_field("addr_high", want.addr_high, m_axis_tdata[55:40]);
      cmp_field("addr_low", want.addr_low, m_axis_tdata[71:56]);
      cmp_field("data_length", 16'(want.data_length), 16'(m_axis_tdata[79:72]));
      cmp_field("reject_reason", 16'(want.reject_reason), 16'(m_axis_tdata[81:80]));
    end
  endtask

  // result side: check taken words, then pick tready for the next cycle
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_word();
      if (stall_req != stalls_seen) begin
        stalls_seen = stall_req;
        hold_left   = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rcv_pct);
      end
    end
  end

  task automatic random_traffic();
    int          sel;
    int          n;
    logic [7:0]  len;
    logic [7:0]  tgt;
    sel = $urandom_range(99);
    if (sel < 8) begin
      // line noise
      n = $urandom_range(1, 6);
      repeat (n) send_byte(8'($urandom_range(255)));
    end else if (sel < 14) begin
      // header with a length that is probably not confirmed
      send_byte(HdrByte);
      send_byte(8'($urandom_range(255)));
      send_byte(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(99) < 20) begin
        n = $urandom_range(1, 3);
        repeat (n) send_byte(8'($urandom_range(255)));
      end
      if ($urandom_range(49) == 0) len = 8'($urandom_range(9, 255));
      else len = 8'($urandom_range(0, 8));
      n = $urandom_range(9);
      if (n < 4) tgt = own_id;
      else if (n < 6) tgt = 8'h00;
      else tgt = 8'($urandom_range(255));
      send_frame(len, tgt, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 $urandom, 1'b1, 8'h00, ($urandom_range(9) == 0),
                 ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : TailByte,
                 1'b0, KindPayload, ReasonNone);
    end
  endtask

  initial begin
    fr_phase   = PhWait;
    own_id     = 8'h01;
    fr_len     = '0;
    pay_cnt    = '0;
    fr_tgt     = '0;
    fr_src     = '0;
    fr_op      = '0;
    fr_addr_hi = '0;
    fr_addr_lo = '0;
    crc_run    = '0;
    crc_rx     = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 9; i++) begin
      for (int p = 0; p < dir_rows[i].npre; p++) send_byte(dir_rows[i].pre[8*p +: 8]);
      send_frame(dir_rows[i].len, dir_rows[i].tgt, dir_rows[i].src, dir_rows[i].op,
                 dir_rows[i].addr, 1'b0, dir_rows[i].pay_base, dir_rows[i].crc_bad,
                 dir_rows[i].tail, 1'b1, dir_rows[i].kind, dir_rows[i].reason);
    end
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_device_id(8'h00);
          snd_pct = 0;
          rcv_pct = 0;
          // long hold on the result side so the input backs up
          stall_req++;
        end
        1: begin
          write_device_id(8'hFF);
          snd_pct = 56;
          rcv_pct = 0;
        end
        2: begin
          write_device_id(8'($urandom_range(255)));
          snd_pct = 0;
          rcv_pct = 56;
        end
        3: begin
          write_device_id(8'($urandom_range(255)));
          snd_pct = 25;
          rcv_pct = 25;
        end
        default: begin
          write_device_id(8'h01);
          snd_pct = 0;
          rcv_pct = 0;
        end
      endcase
      bytes_sent = 0;
      while (bytes_sent < PhaseBytes) random_traffic();
      // finish any open frame before touching device_id
      while (fr_phase != PhWait) send_byte(ZeroByte);
      drain();
    end

    if (err_count == 0) begin
      $display("serial_command_frame_receiver_core_tb: clean");
    end else begin
      $display("serial_command_frame_receiver_core_tb: errors");
    end
    $finish;
  end

endmodule

FILE: serial_command_frame_receiver_core.f
+incdir+hw/rtl
hw/rtl/scfr_pkg.sv
hw/rtl/scfr_parser.sv
hw/rtl/serial_command_frame_receiver_core.sv
tb/serial_command_frame_receiver_core_tb.sv
